@@ rtl/core/gpsc_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gpsc_pkg
// Shared constants, codes and helpers for the grid polygon span cell list.
// ---------------------------------------------------------------------------
package gpsc_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int MAX_CELLS = 63;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_CELLS + 1);

    // shared divider: dividend/quotient and divisor widths
    localparam int DIV_NW = 48;
    localparam int DIV_DW = 24;

    localparam logic signed [31:0] SPAN_EMPTY_MIN = 32'sh7fffffff;
    localparam logic signed [31:0] SPAN_EMPTY_MAX = -32'sh7fffffff;
    localparam int                 SHORT_EDGE     = 16;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_EMIT     = 2'd2,
        OP_NONE     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_CELL_WIDTH = 2'd0,
        CFG_CELL_DEPTH = 2'd1,
        CFG_GRID_COLS  = 2'd2,
        CFG_GRID_ROWS  = 2'd3
    } t_cfg_idx;

    function automatic logic signed [31:0] sat32(input logic signed [DIV_NW-1:0] v);
        logic signed [DIV_NW-1:0] hi_lim;
        logic signed [DIV_NW-1:0] lo_lim;
        hi_lim = DIV_NW'(32'sh7fffffff);
        lo_lim = -hi_lim - DIV_NW'(1);
        if (v > hi_lim) begin
            return 32'sh7fffffff;
        end else if (v < lo_lim) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/gpsc_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// gpsc_div
// Iterative signed divider, truncating toward zero, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module gpsc_div
    import gpsc_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic signed [DIV_NW-1:0] i_dividend,
    input  wire logic signed [DIV_DW-1:0] i_divisor,
    output logic                          o_done,
    output logic signed [DIV_NW-1:0]      o_quotient
);

    localparam int STEP_W = $clog2(DIV_NW);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW:0]   r_rem;
    logic [DIV_DW-1:0] r_dv;
    logic              r_neg;

    logic [DIV_DW:0]   w_trial;
    logic              w_fit;

    // shift in next dividend bit, subtract if it fits
    assign w_trial = {r_rem[DIV_DW-1:0], r_q[DIV_NW-1]};
    assign w_fit   = (w_trial >= {1'b0, r_dv});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt <= STEP_W'(DIV_NW - 1);
            r_q   <= i_dividend[DIV_NW-1] ? DIV_NW'(-i_dividend) : i_dividend;
            r_dv  <= i_divisor[DIV_DW-1] ? DIV_DW'(-i_divisor) : i_divisor;
            r_rem <= '0;
            r_neg <= i_dividend[DIV_NW-1] ^ i_divisor[DIV_DW-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            r_rem <= w_fit ? (w_trial - {1'b0, r_dv}) : w_trial;
            r_q   <= {r_q[DIV_NW-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? $signed(DIV_NW'(-r_q)) : $signed(r_q);

endmodule
`default_nettype wire

@@ rtl/core/grid_polygon_span_cell_list.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// grid_polygon_span_cell_list
// Walks polygon edges across grid rows, keeps a min/max column span per row,
// and emits the list of covered cell indices on request.
// ---------------------------------------------------------------------------
//
//  channel | signals                                     | dir | handshake
//  --------+---------------------------------------------+-----+------------
//  in      | i_operation, i_start_x/z, i_end_x/z         | in  | i_in_valid / o_in_stall
//  out     | o_cell_valid, o_cell_index, o_list_last     | out | o_out_valid / i_out_stall
//  cfg     | i_cfg_index, i_cfg_data                     | in  | i_cfg_valid / o_cfg_ready
//
//  Clear drops all row valid bits at once. Add edge runs on the shared
//  48-step divider: three divides to set up, then for each row the edge
//  crosses inside the grid two divides plus a multiply (one divide for a
//  short edge or the last row) and a read-modify-write of the row store.
//  Emit reads and clamps each row scanned, outputs one cell per free output
//  slot, then the terminator. Reset is synchronous; the row store needs no clearing pass.
//  A stalled output only holds the emit sequencer; a new request is taken
//  only when the sequencer is back in idle.
//
module grid_polygon_span_cell_list
    import gpsc_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,

    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_operation,
    input  wire logic signed [23:0] i_start_x,
    input  wire logic signed [23:0] i_start_z,
    input  wire logic signed [23:0] i_end_x,
    input  wire logic signed [23:0] i_end_z,

    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic                    o_cell_valid,
    output logic [11:0]             o_cell_index,
    output logic                    o_list_last,

    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_DX0   = 20'h00002,   // x0 / xl
        S_DZ0   = 20'h00004,   // z0 / zl
        S_DZ1   = 20'h00008,   // z1 / zl
        S_TZM   = 20'h00010,   // mz * zl in multiplier
        S_TZA   = 20'h00020,   // first row boundary
        S_LOOP  = 20'h00040,   // row walk decision
        S_SKM   = 20'h00080,   // n * zl in multiplier
        S_SKA   = 20'h00100,   // jump boundary over skipped rows
        S_TXM   = 20'h00200,   // crossing product
        S_DTX   = 20'h00400,   // product / (dz >> 4)
        S_DXR   = 20'h00800,   // tx / xl
        S_RD    = 20'h01000,   // row store read
        S_WR    = 20'h02000,   // row store widen
        S_FIN   = 20'h04000,   // tail of walk
        S_DX1   = 20'h08000,   // x1 / xl
        S_ERD   = 20'h10000,   // emit: read row
        S_ECLP  = 20'h20000,   // emit: clamp span
        S_ECELL = 20'h40000,   // emit: one cell per free output slot
        S_ETERM = 20'h80000    // emit: terminator
    } t_state;

    t_state r_state;

    // config
    logic [15:0] r_cell_width;
    logic [15:0] r_cell_depth;
    logic [6:0]  r_grid_cols;
    logic [6:0]  r_grid_rows;

    // edge request
    logic signed [23:0] r_x0, r_z0, r_x1, r_z1;

    // walk state
    logic signed [24:0] r_mz, r_mz1;
    logic signed [31:0] r_tz;
    logic signed [31:0] r_lo, r_hi;
    logic signed [DIV_NW-1:0] r_tx;
    logic               r_final;
    logic               r_skdn;
    logic               r_div_go;

    // multiplier
    logic signed [24:0] r_ma;
    logic signed [23:0] r_mb;
    logic signed [48:0] r_prod;

    // row store
    logic signed [31:0] mem_min [MAX_ROWS];
    logic signed [31:0] mem_max [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_vld;
    logic signed [31:0] r_rd_min, r_rd_max;
    logic               r_rd_vld;

    // emit
    logic [ROW_W-1:0] r_ez;
    logic [11:0]      r_base;
    logic [COL_W-1:0] r_ex, r_ehi;
    logic [CNT_W-1:0] r_cnt;

    // output slot
    logic        r_ov;
    logic        r_ocv;
    logic [11:0] r_oidx;
    logic        r_olast;

    // derived values
    logic [15:0]        w_xl, w_zl;
    logic [6:0]         w_rows, w_cols;
    logic signed [24:0] w_dz;
    logic               w_up, w_dn, w_long, w_xpos;
    logic               w_in_grid;
    logic signed [31:0] w_z1_32, w_zl_32;
    logic signed [25:0] w_mz26, w_mz126, w_rows26, w_na, w_nb, w_n;
    logic signed [32:0] w_tzd;
    logic signed [24:0] w_xd, w_xs;
    logic signed [31:0] w_cur_min, w_cur_max, w_new_min, w_new_max;
    logic signed [31:0] w_elo, w_ehi, w_cmax;
    logic [6:0]         w_ez_n;
    logic [CNT_W:0]     w_cnt_n;
    logic               w_free;
    logic               w_oload;
    logic [ROW_W-1:0]   w_raddr;
    logic               w_div_state, w_div_start, w_div_done;
    logic signed [DIV_NW-1:0] w_div_n, w_div_q;
    logic signed [DIV_DW-1:0] w_div_d;
    logic signed [31:0] w_qsat;

    assign w_xl   = (r_cell_width == '0) ? 16'd1 : r_cell_width;
    assign w_zl   = (r_cell_depth == '0) ? 16'd1 : r_cell_depth;
    assign w_rows = (r_grid_rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : r_grid_rows;
    assign w_cols = (r_grid_cols > 7'(MAX_COLS)) ? 7'(MAX_COLS) : r_grid_cols;

    assign w_dz    = 25'(r_z1) - 25'(r_z0);
    assign w_up    = (r_z1 > r_z0);
    assign w_dn    = (r_z1 < r_z0);
    assign w_long  = (w_dz >= 25'(SHORT_EDGE)) || (w_dz <= -25'(SHORT_EDGE));
    assign w_xpos  = (r_x1 >= r_x0);
    assign w_z1_32 = 32'(r_z1);
    assign w_zl_32 = $signed({16'd0, w_zl});

    assign w_rows26  = $signed({19'd0, w_rows});
    assign w_mz26    = 26'(r_mz);
    assign w_mz126   = 26'(r_mz1);
    assign w_in_grid = !r_mz[24] && (w_mz26 < w_rows26);

    // rows to jump while outside the grid
    always_comb begin
        if (r_mz[24]) begin
            w_na = -w_mz26;
            w_nb = w_mz126 - w_mz26;
        end else begin
            w_na = w_mz26 - (w_rows26 - 26'sd1);
            w_nb = w_mz26 - w_mz126;
        end
        w_n = (w_nb < w_na) ? w_nb : w_na;
    end

    assign w_tzd = 33'(r_tz) - 33'(r_z0);
    assign w_xd  = 25'(r_x1) - 25'(r_x0);
    assign w_xs  = 25'(r_x0) + 25'(r_x1);

    // registered read of the row store; unwritten rows read as empty
    assign w_raddr   = (r_state == S_ERD) ? r_ez : r_mz[ROW_W-1:0];
    assign w_cur_min = r_rd_vld ? r_rd_min : SPAN_EMPTY_MIN;
    assign w_cur_max = r_rd_vld ? r_rd_max : SPAN_EMPTY_MAX;
    assign w_new_min = (r_lo < w_cur_min) ? r_lo : w_cur_min;
    assign w_new_max = (r_hi > w_cur_max) ? r_hi : w_cur_max;

    // emit clamp
    assign w_cmax  = $signed({25'd0, w_cols}) - 32'sd1;
    assign w_elo   = (w_cur_min > 32'sd0) ? w_cur_min : 32'sd0;
    assign w_ehi   = (w_cur_max < w_cmax) ? w_cur_max : w_cmax;
    assign w_ez_n  = {1'b0, r_ez} + 7'd1;
    assign w_cnt_n = {1'b0, r_cnt} + (CNT_W+1)'(1);

    assign w_free  = !r_ov || !i_out_stall;
    // output slot loads a cell or the terminator this cycle
    assign w_oload = w_free && ((r_state == S_ECELL) || (r_state == S_ETERM));

    // shared divider
    assign w_div_state = (r_state == S_DX0) || (r_state == S_DZ0) || (r_state == S_DZ1) ||
                         (r_state == S_DTX) || (r_state == S_DXR) || (r_state == S_DX1);
    assign w_div_start = w_div_state && !r_div_go;

    always_comb begin
        w_div_n = DIV_NW'(r_x0);
        w_div_d = $signed({8'd0, w_xl});
        unique case (r_state)
            S_DZ0: begin
                w_div_n = DIV_NW'(r_z0);
                w_div_d = $signed({8'd0, w_zl});
            end
            S_DZ1: begin
                w_div_n = DIV_NW'(r_z1);
                w_div_d = $signed({8'd0, w_zl});
            end
            S_DTX: begin
                w_div_n = r_prod[DIV_NW-1:0];
                w_div_d = DIV_DW'(w_dz >>> 4);
            end
            S_DXR: w_div_n = r_tx;
            S_DX1: w_div_n = DIV_NW'(r_x1);
            default: w_div_n = DIV_NW'(r_x0);
        endcase
    end

    gpsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_n),
        .i_divisor  (w_div_d),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    assign w_qsat = sat32(w_div_q);

    // multiplier, one registered product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= 49'(r_ma) * 49'(r_mb);
    end

    // row store
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            mem_min[r_mz[ROW_W-1:0]] <= w_new_min;
            mem_max[r_mz[ROW_W-1:0]] <= w_new_max;
        end
        r_rd_min <= mem_min[w_raddr];
        r_rd_max <= mem_max[w_raddr];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cell_width <= 16'd768;
            r_cell_depth <= 16'd768;
            r_grid_cols  <= 7'd16;
            r_grid_rows  <= 7'd16;
            r_vld        <= '0;
            r_rd_vld     <= 1'b0;
            r_ov         <= 1'b0;
            r_div_go     <= 1'b0;
        end else begin
            r_rd_vld <= r_vld[w_raddr];

            if (w_div_start) begin
                r_div_go <= 1'b1;
            end else if (w_div_done) begin
                r_div_go <= 1'b0;
            end

            if (w_oload) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end

            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_CELL_WIDTH: r_cell_width <= i_cfg_data;
                    CFG_CELL_DEPTH: r_cell_depth <= i_cfg_data;
                    CFG_GRID_COLS:  r_grid_cols  <= i_cfg_data[6:0];
                    CFG_GRID_ROWS:  r_grid_rows  <= i_cfg_data[6:0];
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_x0 <= i_start_x;
                        r_z0 <= i_start_z;
                        r_x1 <= i_end_x;
                        r_z1 <= i_end_z;
                        r_final <= 1'b0;
                        r_ez    <= '0;
                        r_base  <= '0;
                        r_cnt   <= '0;
                        unique case (t_op'(i_operation))
                            OP_CLEAR:    r_vld <= '0;
                            OP_ADD_EDGE: r_state <= S_DX0;
                            OP_EMIT:     r_state <= (w_rows == '0) ? S_ETERM : S_ERD;
                            OP_NONE:     r_state <= S_IDLE;
                        endcase
                    end
                end
                S_DX0: begin
                    if (w_div_done) begin
                        r_lo    <= w_qsat;
                        r_hi    <= w_qsat;
                        r_state <= S_DZ0;
                    end
                end
                S_DZ0: begin
                    if (w_div_done) begin
                        r_mz    <= w_div_q[24:0];
                        r_state <= S_DZ1;
                    end
                end
                S_DZ1: begin
                    if (w_div_done) begin
                        r_mz1   <= w_div_q[24:0];
                        r_ma    <= r_mz;
                        r_mb    <= $signed({8'd0, w_zl});
                        r_state <= S_TZM;
                    end
                end
                S_TZM: r_state <= S_TZA;
                S_TZA: begin
                    if (w_up) begin
                        r_tz <= r_prod[31:0] + w_zl_32;
                    end else if (w_dn) begin
                        r_tz <= r_prod[31:0];
                    end else begin
                        r_tz <= 32'(r_z0);
                    end
                    r_state <= S_LOOP;
                end
                S_LOOP: begin
                    if (r_mz == r_mz1) begin
                        r_state <= S_FIN;
                    end else if (w_in_grid) begin
                        if ((w_up && (r_tz >= w_z1_32)) || (w_dn && (r_tz <= w_z1_32))) begin
                            r_state <= S_FIN;
                        end else if (w_long) begin
                            r_ma    <= 25'(w_tzd >>> 2);
                            r_mb    <= 24'(w_xd >>> 2);
                            r_state <= S_TXM;
                        end else begin
                            r_tx    <= DIV_NW'(w_xs >>> 1);
                            r_state <= S_DXR;
                        end
                    end else if ((r_mz[24] && !w_up) || (!r_mz[24] && w_up)) begin
                        // left the grid moving away from it
                        r_state <= S_IDLE;
                    end else begin
                        r_skdn  <= !r_mz[24];
                        r_mz    <= r_mz[24] ? 25'(w_mz26 + w_n) : 25'(w_mz26 - w_n);
                        r_ma    <= 25'(w_n);
                        r_mb    <= $signed({8'd0, w_zl});
                        r_state <= S_SKM;
                    end
                end
                S_SKM: r_state <= S_SKA;
                S_SKA: begin
                    r_tz    <= r_skdn ? (r_tz - r_prod[31:0]) : (r_tz + r_prod[31:0]);
                    r_state <= S_LOOP;
                end
                S_TXM: r_state <= S_DTX;
                S_DTX: begin
                    if (w_div_done) begin
                        r_tx    <= w_div_q + DIV_NW'(r_x0);
                        r_state <= S_DXR;
                    end
                end
                S_DXR: begin
                    if (w_div_done) begin
                        if (w_xpos) begin
                            r_hi <= w_qsat;
                        end else begin
                            r_lo <= w_qsat;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: r_state <= S_WR;
                S_WR: begin
                    r_vld[r_mz[ROW_W-1:0]] <= 1'b1;
                    if (r_final) begin
                        r_state <= S_IDLE;
                    end else begin
                        // carry the crossing column into the next row
                        if (w_xpos) begin
                            r_lo <= r_hi;
                        end else begin
                            r_hi <= r_lo;
                        end
                        if (w_up) begin
                            r_mz <= r_mz + 25'sd1;
                            r_tz <= r_tz + w_zl_32;
                        end else begin
                            r_mz <= r_mz - 25'sd1;
                            r_tz <= r_tz - w_zl_32;
                        end
                        r_state <= S_LOOP;
                    end
                end
                S_FIN: r_state <= w_in_grid ? S_DX1 : S_IDLE;
                S_DX1: begin
                    if (w_div_done) begin
                        if (w_xpos) begin
                            r_hi <= w_qsat;
                        end else begin
                            r_lo <= w_qsat;
                        end
                        r_final <= 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_ERD: r_state <= S_ECLP;
                S_ECLP: begin
                    if (w_elo > w_ehi) begin
                        if (w_ez_n >= w_rows) begin
                            r_state <= S_ETERM;
                        end else begin
                            r_ez    <= r_ez + ROW_W'(1);
                            r_base  <= r_base + 12'(w_cols);
                            r_state <= S_ERD;
                        end
                    end else begin
                        r_ex    <= w_elo[COL_W-1:0];
                        r_ehi   <= w_ehi[COL_W-1:0];
                        r_state <= S_ECELL;
                    end
                end
                S_ECELL: begin
                    if (w_free) begin
                        r_ocv   <= 1'b1;
                        r_oidx  <= r_base + 12'(r_ex);
                        r_olast <= 1'b0;
                        r_cnt   <= w_cnt_n[CNT_W-1:0];
                        if ((r_ex == r_ehi) || (w_cnt_n == (CNT_W+1)'(MAX_CELLS))) begin
                            if ((w_ez_n >= w_rows) || (w_cnt_n == (CNT_W+1)'(MAX_CELLS))) begin
                                r_state <= S_ETERM;
                            end else begin
                                r_ez    <= r_ez + ROW_W'(1);
                                r_base  <= r_base + 12'(w_cols);
                                r_state <= S_ERD;
                            end
                        end else begin
                            r_ex <= r_ex + COL_W'(1);
                        end
                    end
                end
                S_ETERM: begin
                    if (w_free) begin
                        r_ocv   <= 1'b0;
                        r_oidx  <= '0;
                        r_olast <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_ov;
    assign o_cell_valid = r_ocv;
    assign o_cell_index = r_oidx;
    assign o_list_last  = r_olast;

endmodule
`default_nettype wire

@@ tb/tb_grid_polygon_span_cell_list.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb_grid_polygon_span_cell_list
// Self-checking bench for the polygon span cell list. A local span-store
// model walks every accepted edge and predicts each emitted cell list; the
// DUT outputs are compared field by field under several idle/stall mixes.
// ---------------------------------------------------------------------------
module tb_grid_polygon_span_cell_list
    import gpsc_pkg::*;
();

    localparam int WDOG_LIMIT  = 60000;   // cycles with no handshake at all
    localparam int EDGE_SETTLE = 8000;    // wait for the worst add-edge walk to finish

    typedef struct packed {
        logic        cell_valid;
        logic [11:0] cell_index;
        logic        list_last;
    } t_cell_rsp;

    // DUT ports
    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_operation;
    logic signed [23:0] i_start_x;
    logic signed [23:0] i_start_z;
    logic signed [23:0] i_end_x;
    logic signed [23:0] i_end_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic               o_cell_valid;
    logic [11:0]        o_cell_index;
    logic               o_list_last;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [15:0]        i_cfg_data;

    // model state: config registers and the per-row span store
    logic [15:0]        mdl_cell_w;
    logic [15:0]        mdl_cell_d;
    logic [6:0]         mdl_cols;
    logic [6:0]         mdl_rows;
    int                 span_lo [MAX_ROWS];
    int                 span_hi [MAX_ROWS];

    t_cell_rsp          cell_list_q[$];

    int                 send_idle_pct;
    int                 stall_pct;
    int                 n_requests;
    int                 n_cells_checked;
    int                 n_lists;
    int                 n_cfg_writes;
    int                 n_errors;
    int                 idle_cnt;

    grid_polygon_span_cell_list u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_start_x    (i_start_x),
        .i_start_z    (i_start_z),
        .i_end_x      (i_end_x),
        .i_end_z      (i_end_z),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_valid (o_cell_valid),
        .o_cell_index (o_cell_index),
        .o_list_last  (o_list_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // span store model
    // ------------------------------------------------------------------
    function automatic int clip32(longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end
        if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return int'(v);
    endfunction

    function automatic void span_clear();
        for (int r = 0; r < MAX_ROWS; r++) begin
            span_lo[r] = SPAN_EMPTY_MIN;
            span_hi[r] = SPAN_EMPTY_MAX;
        end
    endfunction

    function automatic void span_widen(longint row, longint lo, longint hi);
        longint cur_lo;
        longint cur_hi;
        cur_lo = span_lo[row];
        cur_hi = span_hi[row];
        span_lo[row] = clip32(lo < cur_lo ? lo : cur_lo);
        span_hi[row] = clip32(hi > cur_hi ? hi : cur_hi);
    endfunction

    // Walks one edge row by row. Division truncates toward zero, >>> floors.
    function automatic void span_add_edge(longint x0, longint z0, longint x1, longint z1);
        longint xl, zl, rows, lo, hi, mz, mz1, tz, tx, dz, n;
        bit     up;
        xl   = (mdl_cell_w == 0) ? 1 : longint'(mdl_cell_w);
        zl   = (mdl_cell_d == 0) ? 1 : longint'(mdl_cell_d);
        rows = (mdl_rows > MAX_ROWS) ? MAX_ROWS : longint'(mdl_rows);
        lo   = x0 / xl;
        hi   = lo;
        mz   = z0 / zl;
        mz1  = z1 / zl;
        tz   = z0;
        dz   = z1 - z0;
        up   = z1 > z0;
        if (z1 > z0) begin
            tz = (z0 / zl) * zl + zl;
        end else if (z1 < z0) begin
            tz = (z0 / zl) * zl;
        end
        while (mz != mz1) begin
            if (mz >= 0 && mz < rows) begin
                if (up && tz >= z1) break;
                if (z1 < z0 && tz <= z1) break;
                if (dz >= SHORT_EDGE || dz <= -SHORT_EDGE) begin
                    tx = (((tz - z0) >>> 2) * ((x1 - x0) >>> 2)) / (dz >>> 4) + x0;
                end else begin
                    tx = (x0 + x1) >>> 1;   // short edge: midpoint
                end
                if (x1 >= x0) begin
                    hi = tx / xl;
                    span_widen(mz, lo, hi);
                    lo = hi;
                end else begin
                    lo = tx / xl;
                    span_widen(mz, lo, hi);
                    hi = lo;
                end
            end else begin
                // off-grid: leave if heading away, else skip rows in one jump
                if (mz < 0 && !up) return;
                if (mz >= rows && up) return;
                if (mz < 0) begin
                    n = -mz;
                    if (mz1 - mz < n) n = mz1 - mz;
                    mz += n;
                    tz += n * zl;
                end else begin
                    n = mz - (rows - 1);
                    if (mz - mz1 < n) n = mz - mz1;
                    mz -= n;
                    tz -= n * zl;
                end
                continue;
            end
            if (up) begin
                mz++;
                tz += zl;
            end else begin
                mz--;
                tz -= zl;
            end
        end
        if (mz >= 0 && mz < rows) begin
            if (x1 >= x0) begin
                span_widen(mz, lo, x1 / xl);
            end else begin
                span_widen(mz, x1 / xl, hi);
            end
        end
    endfunction

    // Queues the expected cell list for an emit: capped at MAX_CELLS + terminator.
    function automatic void span_emit();
        longint    rows, cols, lo, hi;
        int        count;
        t_cell_rsp rsp;
        rows  = (mdl_rows > MAX_ROWS) ? MAX_ROWS : longint'(mdl_rows);
        cols  = (mdl_cols > MAX_COLS) ? MAX_COLS : longint'(mdl_cols);
        count = 0;
        for (longint z = 0; z < rows && count < MAX_CELLS; z++) begin
            lo = (span_lo[z] > 0) ? span_lo[z] : 0;
            hi = (span_hi[z] < cols - 1) ? span_hi[z] : cols - 1;
            for (longint x = lo; x <= hi && count < MAX_CELLS; x++) begin
                rsp.cell_valid = 1'b1;
                rsp.cell_index = 12'(z * cols + x);
                rsp.list_last  = 1'b0;
                cell_list_q.push_back(rsp);
                count++;
            end
        end
        rsp.cell_valid = 1'b0;
        rsp.cell_index = '0;
        rsp.list_last  = 1'b1;
        cell_list_q.push_back(rsp);
    endfunction

    // ------------------------------------------------------------------
    // request / config drivers (drive on falling edge, sample on rising)
    // ------------------------------------------------------------------
    task automatic send_request(t_op op, longint sx, longint sz, longint ex, longint ez);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_operation = op;
        i_start_x   = 24'(sx);
        i_start_z   = 24'(sz);
        i_end_x     = 24'(ex);
        i_end_z     = 24'(ez);
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        n_requests++;
        case (op)
            OP_CLEAR:    span_clear();
            OP_ADD_EDGE: span_add_edge(longint'(i_start_x), longint'(i_start_z),
                                       longint'(i_end_x), longint'(i_end_z));
            OP_EMIT:     span_emit();
            default:     ;
        endcase
    endtask

    task automatic wait_list_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (cell_list_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Registers change only with the block idle: results drained and any
    // trailing edge walk given time to finish.
    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        wait_list_drained();
        repeat (EDGE_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        n_cfg_writes++;
        case (idx)
            CFG_CELL_WIDTH: mdl_cell_w = data;
            CFG_CELL_DEPTH: mdl_cell_d = data;
            CFG_GRID_COLS:  mdl_cols   = data[6:0];
            default:        mdl_rows   = data[6:0];
        endcase
    endtask

    task automatic set_grid(int cw, int cd, int cols, int rows);
        write_reg(CFG_CELL_WIDTH, 16'(cw));
        write_reg(CFG_CELL_DEPTH, 16'(cd));
        write_reg(CFG_GRID_COLS, 16'(cols));
        write_reg(CFG_GRID_ROWS, 16'(rows));
    endtask

    task automatic add_edge(longint sx, longint sz, longint ex, longint ez);
        send_request(OP_ADD_EDGE, sx, sz, ex, ez);
    endtask

    // ------------------------------------------------------------------
    // result checker and stall generator
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int exp_v, int got_v);
        $display("mismatch %s: expected %0d got %0d", what, exp_v, got_v);
        n_errors++;
    endtask

    always @(negedge i_clk) begin
        i_out_stall = ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_cell_rsp exp_rsp;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cell_list_q.size() == 0) begin
                report_mismatch("unexpected result, index", -1, o_cell_index);
            end else begin
                exp_rsp = cell_list_q.pop_front();
                n_cells_checked++;
                if (exp_rsp.list_last) n_lists++;
                if (o_cell_valid !== exp_rsp.cell_valid)
                    report_mismatch("cell_valid", exp_rsp.cell_valid, o_cell_valid);
                if (o_cell_index !== exp_rsp.cell_index)
                    report_mismatch("cell_index", exp_rsp.cell_index, o_cell_index);
                if (o_list_last !== exp_rsp.list_last)
                    report_mismatch("list_last", exp_rsp.list_last, o_list_last);
            end
        end
    end

    // watchdog: any handshake on any channel restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            idle_cnt <= 0;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
        if (idle_cnt >= WDOG_LIMIT) begin
            $display("watchdog: no progress, %0d results outstanding", cell_list_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    function automatic longint rand_coord(longint cell_sz, longint n);
        longint lo, hi;
        if (cell_sz == 0) cell_sz = 1;
        lo = -2 * cell_sz;
        hi = (n + 2) * cell_sz;
        if (lo < -8388608) lo = -8388608;
        if (hi > 8388607) hi = 8388607;
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    // Reset-time grid: empty emit, a square, unused op, clear.
    task automatic test_reset_grid();
        send_request(OP_EMIT, 0, 0, 0, 0);
        add_edge(800, 800, 4000, 900);
        add_edge(4000, 900, 3900, 4200);
        add_edge(3900, 4200, 700, 4100);
        add_edge(700, 4100, 800, 800);
        send_request(OP_NONE, 1000, 1000, 9000, 9000);   // ignored
        send_request(OP_EMIT, 0, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        send_request(OP_EMIT, 0, 0, 0, 0);
    endtask

    // Field extremes, short and flat edges, far edges, saturating spans.
    task automatic test_edge_cases();
        add_edge(-8388608, -8388608, 8388607, 8388607);
        add_edge(8388607, 8388607, -8388608, -8388608);
        add_edge(100, 5000, 9000, 5010);                  // short edge, up
        add_edge(9000, 3010, 100, 3000);                  // short edge, down
        add_edge(-3000, 2000, 20000, 2000);               // flat edge
        add_edge(1000, -900000, 2000, -20000);            // below grid, never enters
        add_edge(1000, 900000, 2000, 50000);              // above grid, never enters
        add_edge(5000, -50000, 6000, 50000);              // crosses every row
        send_request(OP_EMIT, 0, 0, 0, 0);
    endtask

    // Register extremes: zero cell size, empty grid, oversized grid, cap.
    task automatic test_register_extremes();
        set_grid(0, 0, 0, 0);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        add_edge(0, 0, 3, 5);
        send_request(OP_EMIT, 0, 0, 0, 0);                // terminator only
        set_grid(1, 1, 127, 127);
        add_edge(-100, -5, 200, 70);
        add_edge(200, 70, -100, 2);
        send_request(OP_EMIT, 0, 0, 0, 0);                // hits the cell cap
        set_grid(65535, 65535, 64, 64);
        send_request(OP_CLEAR, 0, 0, 0, 0);
        add_edge(-8388608, 8388607, 8388607, -8388608);
        send_request(OP_EMIT, 0, 0, 0, 0);
    endtask

    // Mostly closed polygons with random vertices near the grid, some noise.
    task automatic test_random_polygons(int n_items, int idle_pct, int stl_pct, int max_rows);
        int     target;
        int     k;
        longint vx[6];
        longint vz[6];
        target        = n_requests + n_items;
        set_grid(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 4000),
                 ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(1, 4000),
                 $urandom_range(1, 64), $urandom_range(1, max_rows));
        send_idle_pct = idle_pct;
        stall_pct     = stl_pct;
        while (n_requests < target) begin
            if ($urandom_range(9) == 0) begin
                send_request(t_op'($urandom_range(3)), $urandom, $urandom, $urandom, $urandom);
            end else begin
                if ($urandom_range(3) != 0) send_request(OP_CLEAR, 0, 0, 0, 0);
                k = $urandom_range(3, 6);
                for (int v = 0; v < k; v++) begin
                    vx[v] = rand_coord(mdl_cell_w, mdl_cols);
                    vz[v] = rand_coord(mdl_cell_d, (mdl_rows > 64) ? 64 : mdl_rows);
                end
                for (int v = 0; v < k; v++) begin
                    if ($urandom_range(19) == 0) continue;     // broken outline
                    add_edge(vx[v], vz[v], vx[(v + 1) % k], vz[(v + 1) % k]);
                end
                send_request(OP_EMIT, 0, 0, 0, 0);
            end
        end
    endtask

    // ------------------------------------------------------------------
    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_operation   = OP_CLEAR;
        i_start_x     = '0;
        i_start_z     = '0;
        i_end_x       = '0;
        i_end_z       = '0;
        i_out_stall   = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_CELL_WIDTH;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        n_requests    = 0;
        n_cells_checked = 0;
        n_lists       = 0;
        n_cfg_writes  = 0;
        n_errors      = 0;
        idle_cnt      = 0;
        mdl_cell_w    = 16'd768;
        mdl_cell_d    = 16'd768;
        mdl_cols      = 7'd16;
        mdl_rows      = 7'd16;
        span_clear();

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_grid();
        test_edge_cases();
        test_register_extremes();
        test_random_polygons(70, 0, 0, 16);
        wait_list_drained();                    // let the pipe run dry once
        test_random_polygons(60, 88, 0, 16);
        test_random_polygons(60, 0, 88, 16);
        test_random_polygons(60, 38, 38, 16);
        test_random_polygons(20, 0, 0, 64);
        test_random_polygons(50, 0, 0, 12);

        wait_list_drained();
        repeat (EDGE_SETTLE) @(posedge i_clk);

        $display("covered %0d requests, %0d results in %0d cell lists, %0d register writes",
                 n_requests, n_cells_checked, n_lists, n_cfg_writes);
        $display("idle mixes: none, sender, receiver, both; %0d mismatches", n_errors);
        if (n_errors == 0 && cell_list_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire
